[rtl/bpa_pkg.sv]
// Shared constants, codes, types and helpers of the buddy page allocator.
`default_nettype none
package bpa_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int LOG2_POOL  = $clog2(POOL_PAGES);
    localparam int TREE_NODES = 2 * POOL_PAGES - 1;

    // node index and node value widths follow the pool size
    localparam int IDX_W = LOG2_POOL + 1;
    localparam int VAL_W = LOG2_POOL + 1;

    // fixed field widths of the channels
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 11;
    localparam int PAGE_W  = 10;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // smallest power of two not below n (n in 1..POOL_PAGES)
    function automatic logic [VAL_W-1:0] f_round_pow2(input logic [COUNT_W-1:0] n);
        logic [VAL_W-1:0] p;
        logic             found;
        p     = '0;
        found = 1'b0;
        for (int k = 0; k < VAL_W; k++) begin
            if (!found && ((32'd1 << k) >= 32'(n))) begin
                p     = VAL_W'(32'd1 << k);
                found = 1'b1;
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/bpa_if.sv]
// Request and response channel interfaces of the buddy page allocator.
`default_nettype none
interface bpa_req_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] page_count;
    logic [PAGE_W-1:0]  page_index;

    modport source (output valid, output cmd, output page_count, output page_index,
                    input ready);
    modport sink   (input valid, input cmd, input page_count, input page_index,
                    output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] block_start;
    logic [VAL_W-1:0]  largest_free;

    modport source (output valid, output status, output block_start, output largest_free,
                    input ready);
    modport sink   (input valid, input status, input block_start, input largest_free,
                    output ready);
endinterface
`default_nettype wire

[rtl/bpa_tree_store.sv]
// Longest-free tree memory with its clearing pass to the all-free pattern.
`default_nettype none
module bpa_tree_store import bpa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_init,
    input  wire t_mem_req         i_mem,
    output logic [VAL_W-1:0]      o_rdata,
    output logic                  o_busy
);

    logic [VAL_W-1:0] r_mem [TREE_NODES];
    logic [VAL_W-1:0] r_rdata;

    logic             r_busy,   n_busy;
    logic [IDX_W-1:0] r_sw_idx, n_sw_idx;
    logic [VAL_W-1:0] r_sw_val, n_sw_val;
    logic [IDX_W:0]   r_sw_last, n_sw_last;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [VAL_W-1:0] w_wdata;

    always_comb begin
        n_busy    = r_busy;
        n_sw_idx  = r_sw_idx;
        n_sw_val  = r_sw_val;
        n_sw_last = r_sw_last;
        if (i_init) begin
            n_busy    = 1'b1;
            n_sw_idx  = '0;
            n_sw_val  = VAL_W'(POOL_PAGES);
            n_sw_last = '0;
        end else if (r_busy) begin
            n_sw_idx = r_sw_idx + IDX_W'(1);
            // last node of a level: halve the size, move to the next level end
            if ({1'b0, r_sw_idx} == r_sw_last) begin
                n_sw_val  = r_sw_val >> 1;
                n_sw_last = {r_sw_last[IDX_W-1:0], 1'b0} + (IDX_W+1)'(2);
            end
            if (32'(r_sw_idx) == TREE_NODES - 1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        if (r_busy) begin
            w_we    = 1'b1;
            w_waddr = r_sw_idx;
            w_wdata = r_sw_val;
        end else begin
            w_we    = i_mem.we;
            w_waddr = i_mem.waddr;
            w_wdata = i_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_sw_idx  <= '0;
            r_sw_val  <= VAL_W'(POOL_PAGES);
            r_sw_last <= '0;
        end else begin
            r_busy    <= n_busy;
            r_sw_idx  <= n_sw_idx;
            r_sw_val  <= n_sw_val;
            r_sw_last <= n_sw_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_mem.raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy | i_init;

endmodule
`default_nettype wire

[rtl/buddy_page_allocator.sv]
// Binary buddy page allocator: request/response channels around the tree walker.
//
// Request word: cmd (allocate, free, reinitialise), page_count, page_index.
// Response word: status, block_start, largest_free. One response per request.
// The tree of longest free runs sits in one memory with a registered read;
// every step of a walk reads one node and writes at most one node.
// Allocate of 2^k pages: a check, a descent to a node of that size, a climb
// back up to the root (for the whole pool, neither), then a load of the
// response register. Free: a climb from the leaf to the used node, a climb
// back up to the root, then the same load; a free that is not a block start
// stops at the used node. Other failed checks go from the check straight to
// the response register.
// Reinitialise runs a clearing pass over all 2*POOL_PAGES - 1 nodes (2047 at
// 1024 pages), one a cycle, then answers.
// After reset the same clearing pass runs with i_req.ready low.
// One request is worked on at a time; a new one is taken as soon as the
// previous one is in the response register, even while that response waits.
// If o_rsp is stalled, a finished result holds in the walker until the
// response register empties.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);

    localparam logic [2:0] S_RST_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DESC     = 3'd2;
    localparam logic [2:0] S_FUP      = 3'd3;
    localparam logic [2:0] S_UP       = 3'd4;
    localparam logic [2:0] S_INIT_CLR = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]           r_state,    n_state;
    logic                 r_is_free,  n_is_free;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [VAL_W-1:0]     r_size,     n_size;
    logic [VAL_W-1:0]     r_val,      n_val;
    logic [VAL_W-1:0]     r_want,     n_want;
    logic [LOG2_POOL-1:0] r_start,    n_start;
    logic [PAGE_W-1:0]    r_page,     n_page;
    logic [STAT_W-1:0]    r_status,   n_status;
    logic [VAL_W-1:0]     r_root,     n_root;
    logic                 r_ovalid,   n_ovalid;
    logic [STAT_W-1:0]    r_o_status, n_o_status;
    logic [PAGE_W-1:0]    r_o_start,  n_o_start;
    logic [VAL_W-1:0]     r_o_large,  n_o_large;

    t_mem_req             w_mem;
    logic                 w_init;
    logic [VAL_W-1:0]     w_rdata;
    logic                 w_busy;

    logic [VAL_W-1:0]     w_want;
    logic [IDX_W-1:0]     w_left;
    logic [IDX_W-1:0]     w_nidx;
    logic [VAL_W-1:0]     w_nsize;
    logic                 w_go_left;
    logic [IDX_W-1:0]     w_parent;
    logic [VAL_W-1:0]     w_psize;
    logic [VAL_W:0]       w_sum;
    logic [VAL_W-1:0]     w_pval;
    logic                 w_aligned;

    function automatic logic [IDX_W-1:0] f_sib(input logic [IDX_W-1:0] idx);
        return idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] f_left(input logic [IDX_W-1:0] idx);
        return {idx[IDX_W-2:0], 1'b0} + IDX_W'(1);
    endfunction

    bpa_tree_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (w_init),
        .i_mem   (w_mem),
        .o_rdata (w_rdata),
        .o_busy  (w_busy)
    );

    assign w_want    = f_round_pow2(i_req.page_count);
    assign w_left    = f_left(r_idx);
    assign w_go_left = (w_rdata >= r_want);
    assign w_nidx    = w_go_left ? w_left : w_left + IDX_W'(1);
    assign w_nsize   = r_size >> 1;
    assign w_parent  = (r_idx - IDX_W'(1)) >> 1;
    assign w_psize   = {r_size[VAL_W-2:0], 1'b0};
    assign w_sum     = {1'b0, r_val} + {1'b0, w_rdata};
    // free merges two fully free buddies; otherwise keep the larger child
    assign w_pval    = (r_is_free && (w_sum == {1'b0, w_psize})) ? w_psize
                     : ((r_val > w_rdata) ? r_val : w_rdata);
    assign w_aligned = ((VAL_W'(r_page) & (r_size - VAL_W'(1))) == '0);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_is_free  = r_is_free;
        n_idx      = r_idx;
        n_size     = r_size;
        n_val      = r_val;
        n_want     = r_want;
        n_start    = r_start;
        n_page     = r_page;
        n_status   = r_status;
        n_root     = r_root;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_start  = r_o_start;
        n_o_large  = r_o_large;
        w_mem      = '0;
        w_init     = 1'b0;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_RST_CLR: begin
                if (!w_busy) begin
                    n_root  = VAL_W'(POOL_PAGES);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_is_free = (i_req.cmd == CMD_FREE);
                    n_want    = w_want;
                    n_page    = i_req.page_index;
                    n_start   = '0;
                    n_state   = S_DONE;
                    unique case (i_req.cmd)
                        CMD_ALLOC: begin
                            if (i_req.page_count == '0
                                || 32'(i_req.page_count) > POOL_PAGES) begin
                                n_status = ST_INVALID;
                            end else if (r_root < w_want) begin
                                n_status = ST_NOFIT;
                            end else if (32'(w_want) == POOL_PAGES) begin
                                // whole pool: mark the root, no walk
                                w_mem.we    = 1'b1;
                                w_mem.waddr = '0;
                                w_mem.wdata = '0;
                                n_root      = '0;
                                n_status    = ST_OK;
                            end else begin
                                w_mem.raddr = IDX_W'(1);
                                n_idx       = '0;
                                n_size      = VAL_W'(POOL_PAGES);
                                n_state     = S_DESC;
                            end
                        end
                        CMD_FREE: begin
                            if (32'(i_req.page_index) >= POOL_PAGES) begin
                                n_status = ST_INVALID;
                            end else begin
                                n_idx       = IDX_W'(i_req.page_index)
                                            + IDX_W'(POOL_PAGES - 1);
                                w_mem.raddr = IDX_W'(i_req.page_index)
                                            + IDX_W'(POOL_PAGES - 1);
                                n_size      = VAL_W'(1);
                                n_state     = S_FUP;
                            end
                        end
                        CMD_INIT: begin
                            w_init  = 1'b1;
                            n_state = S_INIT_CLR;
                        end
                        default: begin
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_DESC: begin
                // read data holds the left child of r_idx
                n_idx  = w_nidx;
                n_size = w_nsize;
                if (!w_go_left) begin
                    n_start = r_start + LOG2_POOL'(w_nsize);
                end
                if (w_nsize == r_want) begin
                    w_mem.we    = 1'b1;
                    w_mem.waddr = w_nidx;
                    w_mem.wdata = '0;
                    w_mem.raddr = f_sib(w_nidx);
                    n_val       = '0;
                    n_state     = S_UP;
                end else begin
                    w_mem.raddr = f_left(w_nidx);
                end
            end
            S_FUP: begin
                // read data holds node r_idx on the climb from the leaf
                if (w_rdata == '0) begin
                    if (!w_aligned) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        w_mem.we    = 1'b1;
                        w_mem.waddr = r_idx;
                        w_mem.wdata = r_size;
                        if (r_idx == '0) begin
                            n_root   = r_size;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else begin
                            w_mem.raddr = f_sib(r_idx);
                            n_val       = r_size;
                            n_state     = S_UP;
                        end
                    end
                end else if (r_idx == '0) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_idx       = w_parent;
                    n_size      = w_psize;
                    w_mem.raddr = w_parent;
                end
            end
            S_UP: begin
                // read data holds the sibling of r_idx; r_val is r_idx's new value
                w_mem.we    = 1'b1;
                w_mem.waddr = w_parent;
                w_mem.wdata = w_pval;
                n_idx       = w_parent;
                n_size      = w_psize;
                n_val       = w_pval;
                if (w_parent == '0) begin
                    n_root   = w_pval;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    w_mem.raddr = f_sib(w_parent);
                end
            end
            S_INIT_CLR: begin
                if (!w_busy) begin
                    n_root   = VAL_W'(POOL_PAGES);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the response register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_start  = (r_status == ST_OK && !r_is_free) ? PAGE_W'(r_start)
                                                                   : '0;
                    n_o_large  = r_root;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RST_CLR;
            r_ovalid <= 1'b0;
            r_root   <= VAL_W'(POOL_PAGES);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_root   <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_free  <= n_is_free;
        r_idx      <= n_idx;
        r_size     <= n_size;
        r_val      <= n_val;
        r_want     <= n_want;
        r_start    <= n_start;
        r_page     <= n_page;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_start  <= n_o_start;
        r_o_large  <= n_o_large;
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.block_start  = r_o_start;
    assign o_rsp.largest_free = r_o_large;

    a_desc_above_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DESC) |-> (r_size > r_want))
        else $error("descent reached a node no larger than the request");

    a_up_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP && w_parent != '0) |-> (w_mem.waddr != w_mem.raddr))
        else $error("climb reads and writes the same node");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("response loaded outside the done state");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_root <= VAL_W'(POOL_PAGES)))
        else $error("largest free run exceeds the pool");

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench of the buddy page allocator: random stimulus, tree predictor and scoreboard.
`timescale 1ns / 1ps

module tb;
    import bpa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 8000;
    localparam int LONG_HOLD    = 250;
    localparam int RANDOM_WORDS = 1000;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PAGE_W-1:0]  block_start;
        logic [VAL_W-1:0]   largest_free;
    } t_reply;

    class alloc_scoreboard;
        logic [VAL_W-1:0] run_len [TREE_NODES];
        t_reply           due_replies [$];
        int               failures;

        function new();
            failures = 0;
            rebuild_tree();
        endfunction

        function void rebuild_tree();
            int first, width, span;
            first = 0;
            width = 1;
            span  = POOL_PAGES;
            while (first < TREE_NODES) begin
                for (int k = 0; k < width; k++) run_len[first + k] = VAL_W'(span);
                first += width;
                width *= 2;
                span  >>= 1;
            end
        endfunction

        function logic [VAL_W-1:0] wider(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
            return (a > b) ? a : b;
        endfunction

        function void grant_block(input logic [COUNT_W-1:0] count,
                                  output logic [STAT_W-1:0] status,
                                  output logic [PAGE_W-1:0] start);
            int want, idx, span;
            start = '0;
            if (count == 0 || count > POOL_PAGES) begin
                status = ST_INVALID;
                return;
            end
            want = 1;
            while (want < count) want <<= 1;
            if (run_len[0] < want) begin
                status = ST_NOFIT;
                return;
            end
            idx  = 0;
            span = POOL_PAGES;
            // descend left-first to a node of the rounded size
            while (span != want) begin
                idx  = (run_len[2 * idx + 1] >= want) ? 2 * idx + 1 : 2 * idx + 2;
                span >>= 1;
            end
            run_len[idx] = '0;
            start  = PAGE_W'((idx + 1) * span - POOL_PAGES);
            status = ST_OK;
            while (idx != 0) begin
                idx = (idx - 1) / 2;
                run_len[idx] = wider(run_len[2 * idx + 1], run_len[2 * idx + 2]);
            end
        endfunction

        function logic [STAT_W-1:0] release_block(input logic [PAGE_W-1:0] page);
            int idx, span, l, r;
            idx  = page + POOL_PAGES - 1;
            span = 1;
            // climb to the first used node
            while (run_len[idx] != 0) begin
                if (idx == 0) return ST_INVALID;
                idx  = (idx - 1) / 2;
                span <<= 1;
            end
            if ((page & (span - 1)) != 0) return ST_INVALID;
            run_len[idx] = VAL_W'(span);
            while (idx != 0) begin
                idx  = (idx - 1) / 2;
                span <<= 1;
                l = run_len[2 * idx + 1];
                r = run_len[2 * idx + 2];
                // merge buddies that are both wholly free
                run_len[idx] = (l + r == span) ? VAL_W'(span) : VAL_W'((l > r) ? l : r);
            end
            return ST_OK;
        endfunction

        function void note_request(input logic [CMD_W-1:0] cmd,
                                   input logic [COUNT_W-1:0] count,
                                   input logic [PAGE_W-1:0] page,
                                   output logic [STAT_W-1:0] status,
                                   output logic [PAGE_W-1:0] start);
            t_reply want;
            start = '0;
            case (cmd)
                CMD_ALLOC: grant_block(count, status, start);
                CMD_FREE:  status = release_block(page);
                CMD_INIT: begin
                    rebuild_tree();
                    status = ST_OK;
                end
                default:   status = ST_INVALID;
            endcase
            want.status       = status;
            want.block_start  = start;
            want.largest_free = run_len[0];
            due_replies.push_back(want);
        endfunction

        function void check_response(input t_reply got);
            t_reply want;
            if (due_replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected reply status=%0d start=%0d largest=%0d",
                             $realtime, got.status, got.block_start, got.largest_free);
                return;
            end
            want = due_replies.pop_front();
            if (got.status !== want.status || got.block_start !== want.block_start ||
                    got.largest_free !== want.largest_free) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: reply mismatch expected %0d/%0d/%0d got %0d/%0d/%0d",
                             $realtime, want.status, want.block_start, want.largest_free,
                             got.status, got.block_start, got.largest_free);
            end
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alloc_scoreboard sb = new();
    int  live_starts [$];
    bit  no_idle;
    bit  hold_request;
    int  quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // end the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [COUNT_W-1:0] count,
                             input logic [PAGE_W-1:0] page);
        int gap;
        logic [STAT_W-1:0] st;
        logic [PAGE_W-1:0] start;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.page_count <= count;
        req_ch.page_index <= page;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(cmd, count, page, st, start);
        if (cmd == CMD_ALLOC && st == ST_OK) live_starts.push_back(start);
        if (cmd == CMD_INIT) live_starts.delete();
        if (cmd == CMD_FREE && st == ST_OK) begin
            for (int k = live_starts.size() - 1; k >= 0; k--)
                if (live_starts[k] == page) live_starts.delete(k);
        end
        @(negedge i_clk);
    endtask

    // drain until every expected word has come back
    task automatic pause_sender();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    initial begin
        int stall;
        t_reply got;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got.status       = rsp_ch.status;
            got.block_start  = rsp_ch.block_start;
            got.largest_free = rsp_ch.largest_free;
            sb.check_response(got);
            @(negedge i_clk);
        end
    end

    initial begin
        int pick, span;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  page;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_ALLOC;
        req_ch.page_count = '0;
        req_ch.page_index = '0;
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        quiet_cycles      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad counts, full pool, no fit, bad frees, unknown command, reinitialise
        send_word(CMD_ALLOC, 11'd0, 10'd1023);
        send_word(CMD_ALLOC, 11'd1025, 10'd0);
        send_word(CMD_ALLOC, 11'd2047, 10'd512);
        send_word(CMD_ALLOC, 11'd1024, 10'd0);
        send_word(CMD_ALLOC, 11'd1, 10'd0);
        send_word(CMD_FREE, 11'd2047, 10'd1023);
        send_word(CMD_FREE, 11'd0, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd0);
        send_word(CMD_ALLOC, 11'd1, 10'd0);
        send_word(CMD_ALLOC, 11'd3, 10'd0);
        send_word(CMD_ALLOC, 11'd512, 10'd0);
        send_word(CMD_ALLOC, 11'd300, 10'd0);
        send_word(CMD_ALLOC, 11'd256, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd5);
        send_word(CMD_FREE, 11'd0, 10'd4);
        send_word(CMD_FREE, 11'd0, 10'd512);
        send_word(CMD_UNUSED, 11'd1365, 10'd682);
        send_word(CMD_UNUSED, 11'd682, 10'd341);
        send_word(CMD_INIT, 11'd2047, 10'd1023);
        send_word(CMD_ALLOC, 11'd2, 10'd1023);
        send_word(CMD_ALLOC, 11'd1, 10'd0);
        send_word(CMD_FREE, 11'd0, 10'd1023);
        send_word(CMD_FREE, 11'd0, 10'd2);
        pause_sender();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 300) hold_request = 1'b1;
            if (n == 500) pause_sender();
            no_idle = (n >= 700 && n < 800);
            pick  = $urandom_range(0, 99);
            count = COUNT_W'($urandom_range(0, 2047));
            page  = PAGE_W'($urandom_range(0, 1023));
            if (pick < 45 || (pick < 80 && live_starts.size() == 0)) begin
                span = $urandom_range(0, 19);
                if (span < 16) count = COUNT_W'($urandom_range(1, 16));
                else if (span < 19) count = COUNT_W'($urandom_range(1, 256));
                else count = COUNT_W'($urandom_range(1, POOL_PAGES));
                send_word(CMD_ALLOC, count, page);
            end else if (pick < 80) begin
                page = PAGE_W'(live_starts[$urandom_range(0, live_starts.size() - 1)]);
                send_word(CMD_FREE, count, page);
            end else if (pick < 85 && live_starts.size() != 0) begin
                // land one to three pages past a live block's first page, usually inside it
                page = PAGE_W'(live_starts[$urandom_range(0, live_starts.size() - 1)]
                               + $urandom_range(1, 3));
                send_word(CMD_FREE, count, page);
            end else if (pick < 90) begin
                send_word(CMD_FREE, count, page);
            end else if (pick < 94) begin
                count = ($urandom_range(0, 1) != 0) ? 11'd0 :
                        COUNT_W'($urandom_range(POOL_PAGES + 1, 2047));
                send_word(CMD_ALLOC, count, page);
            end else if (pick < 96) begin
                send_word(CMD_UNUSED, count, page);
            end else if (pick < 97) begin
                send_word(CMD_INIT, count, page);
            end else begin
                send_word(CMD_ALLOC, count, page);
            end
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
